/* design/blr_pkg.sv */
// Shared constants for the Bresenham line rasterizer.
// No dependencies; imported by every module of the block.
package blr_pkg;

	localparam int FIELD_BITS      = 6;   // width of every coordinate field on the ports
	localparam int COORD_BITS_DEF  = 6;
	localparam int IMG_BITS        = 7;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;
	localparam int S_TDATA_BITS    = 4 * FIELD_BITS;
	localparam int M_TDATA_BITS    = 16;

	localparam logic [IMG_BITS-1:0] IMG_SIZE_RESET = IMG_BITS'(64);

	// register index, taken from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

endpackage

/* design/blr_cfg.sv */
// APB register file: image_width and image_height.
// Depends on blr_pkg.
module blr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [blr_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [blr_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [blr_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	output logic [blr_pkg::IMG_BITS-1:0]      image_width,
	output logic [blr_pkg::IMG_BITS-1:0]      image_height
);
	import blr_pkg::*;

	logic [IMG_BITS-1:0] width_q;
	logic [IMG_BITS-1:0] height_q;
	logic                wr_en;
	logic                reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_SIZE_RESET;
			height_q <= IMG_SIZE_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[IMG_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[IMG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign image_width  = width_q;
	assign image_height = height_q;

endmodule

/* design/blr_setup.sv */
// Line setup: picks the major axis, orders the endpoints and finds the deltas.
// Depends on blr_pkg.
module blr_setup #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] sx,
	input  logic [COORD_BITS-1:0] sy,
	input  logic [COORD_BITS-1:0] ex,
	input  logic [COORD_BITS-1:0] ey,
	output logic [COORD_BITS-1:0] maj_start,
	output logic [COORD_BITS-1:0] min_start,
	output logic [COORD_BITS-1:0] maj_end,
	output logic [COORD_BITS-1:0] maj_delta,
	output logic [COORD_BITS-1:0] min_delta,
	output logic                  min_neg,
	output logic                  x_major
);
	import blr_pkg::*;

	logic [COORD_BITS-1:0] dx, dy, min_end;
	logic                  swap;

	always_comb begin
		dx      = (ex > sx) ? ex - sx : sx - ex;
		dy      = (ey > sy) ? ey - sy : sy - ey;
		x_major = dx > dy;   // ties go to y
		if (x_major) begin
			swap      = ex < sx;
			maj_start = swap ? ex : sx;
			min_start = swap ? ey : sy;
			maj_end   = swap ? sx : ex;
			min_end   = swap ? sy : ey;
			maj_delta = dx;
			min_delta = dy;
		end else begin
			swap      = ey < sy;
			maj_start = swap ? ey : sy;
			min_start = swap ? ex : sx;
			maj_end   = swap ? sy : ey;
			min_end   = swap ? sx : ex;
			maj_delta = dy;
			min_delta = dx;
		end
		min_neg = min_end < min_start;
	end

endmodule

/* design/blr_walk.sv */
// Pixel walker: one shared error/step unit advances one pixel per cycle while the output is not stalled,
// with a registered output stage. Depends on blr_pkg.
module blr_walk #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [COORD_BITS-1:0]             maj_start,
	input  logic [COORD_BITS-1:0]             min_start,
	input  logic [COORD_BITS-1:0]             maj_end,
	input  logic [COORD_BITS-1:0]             maj_delta,
	input  logic [COORD_BITS-1:0]             min_delta,
	input  logic                              min_neg,
	input  logic                              x_major,
	input  logic [blr_pkg::IMG_BITS-1:0]      image_width,
	input  logic [blr_pkg::IMG_BITS-1:0]      image_height,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [blr_pkg::FIELD_BITS-1:0]    pixel_x,
	output logic [blr_pkg::FIELD_BITS-1:0]    pixel_y,
	output logic                              visible,
	output logic                              last
);
	import blr_pkg::*;

	localparam int ERR_BITS = COORD_BITS + 3;

	logic                       busy_q;
	logic [COORD_BITS-1:0]      maj_q, min_q, maj_end_q, maj_d_q, min_d_q;
	logic                       neg_q, xm_q;
	logic signed [ERR_BITS-1:0] err_q;

	logic                       out_valid_q;
	logic [FIELD_BITS-1:0]      px_q, py_q;
	logic                       vis_q, last_q;

	logic                       advance;
	logic                       at_end;
	logic signed [ERR_BITS-1:0] err_sum, err_nxt, maj_d_s, min_d_s;
	logic                       step_min;
	logic [FIELD_BITS-1:0]      cur_px, cur_py;

	assign advance = busy_q && (!out_valid_q || out_ready);
	assign at_end  = maj_q == maj_end_q;
	assign maj_d_s = $signed(ERR_BITS'(maj_d_q));
	assign min_d_s = $signed(ERR_BITS'(min_d_q));

	// shared error unit: add minor delta, test 2*err >= major delta, pull back
	always_comb begin
		err_sum  = err_q + min_d_s;
		step_min = (err_sum <<< 1) >= maj_d_s;
		err_nxt  = step_min ? err_sum - maj_d_s : err_sum;
		cur_px   = FIELD_BITS'(xm_q ? maj_q : min_q);
		cur_py   = FIELD_BITS'(xm_q ? min_q : maj_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (advance && at_end)
				busy_q <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			maj_q     <= maj_start;
			min_q     <= min_start;
			maj_end_q <= maj_end;
			maj_d_q   <= maj_delta;
			min_d_q   <= min_delta;
			neg_q     <= min_neg;
			xm_q      <= x_major;
			err_q     <= '0;
		end else if (advance) begin
			maj_q <= maj_q + 1'b1;
			if (step_min)
				min_q <= neg_q ? min_q - 1'b1 : min_q + 1'b1;
			err_q <= err_nxt;
		end
		if (advance) begin
			px_q   <= cur_px;
			py_q   <= cur_py;
			vis_q  <= ({1'b0, cur_px} < image_width) && ({1'b0, cur_py} < image_height);
			last_q <= at_end;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign visible   = vis_q;
	assign last      = last_q;

	// a line ends only by registering its final pixel
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q && last_q)
		else $error("walker went idle without emitting the last pixel");

	// the walk never passes the major endpoint
	a_maj_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> maj_q <= maj_end_q)
		else $error("major coordinate beyond line end");

	// error stays within one major delta of zero
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (err_q <= maj_d_s) && (-err_q <= maj_d_s))
		else $error("error accumulator out of bounds");

	// no new line is loaded over one in flight
	a_no_reload: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !load)
		else $error("line loaded while walker busy");

endmodule

/* design/bresenham_line_rasterizer.sv */
// Bresenham line rasterizer, top level. A line with major delta d gives d+1 pixels.
// Throughput: one pixel per cycle from the shared step unit while m_tready is high;
// s_tready is low while a line is walked, so a new line waits until the last pixel of the one before is registered.
// Reset (arst_n, async): walker idle, output empty, image size registers at 64.
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [blr_pkg::S_TDATA_BITS-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [blr_pkg::M_TDATA_BITS-1:0]  m_tdata,  // pixel_x, pixel_y, 4'b0 pad
	output logic                              m_tuser,  // visible
	output logic                              m_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [blr_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [blr_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [blr_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready
);
	import blr_pkg::*;

	logic [IMG_BITS-1:0]   image_width, image_height;
	logic                  busy, load;
	logic [COORD_BITS-1:0] maj_start, min_start, maj_end, maj_delta, min_delta;
	logic                  min_neg, x_major;
	logic [FIELD_BITS-1:0] pixel_x, pixel_y;

	assign s_tready = !busy;
	assign load     = s_tvalid && s_tready;

	blr_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.image_width  (image_width),
		.image_height (image_height)
	);

	blr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.sx        (s_tdata[0*FIELD_BITS +: COORD_BITS]),
		.sy        (s_tdata[1*FIELD_BITS +: COORD_BITS]),
		.ex        (s_tdata[2*FIELD_BITS +: COORD_BITS]),
		.ey        (s_tdata[3*FIELD_BITS +: COORD_BITS]),
		.maj_start (maj_start),
		.min_start (min_start),
		.maj_end   (maj_end),
		.maj_delta (maj_delta),
		.min_delta (min_delta),
		.min_neg   (min_neg),
		.x_major   (x_major)
	);

	blr_walk #(.COORD_BITS(COORD_BITS)) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.maj_start    (maj_start),
		.min_start    (min_start),
		.maj_end      (maj_end),
		.maj_delta    (maj_delta),
		.min_delta    (min_delta),
		.min_neg      (min_neg),
		.x_major      (x_major),
		.image_width  (image_width),
		.image_height (image_height),
		.busy         (busy),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.visible      (m_tuser),
		.last         (m_tlast)
	);

	assign m_tdata = M_TDATA_BITS'({pixel_y, pixel_x});

endmodule

/* sim/tb_bresenham_line_rasterizer.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bresenham_line_rasterizer: scoreboard with a line predictor,
// stream drivers with random gaps and stalls, and APB writes of the image size registers.
// Depends on blr_pkg and the rasterizer RTL only.
module tb_bresenham_line_rasterizer;
	import blr_pkg::*;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_IMAGE_WIDTH  = APB_ADDR_BITS'(0);
	localparam logic [APB_ADDR_BITS-1:0] ADDR_IMAGE_HEIGHT = APB_ADDR_BITS'(4);
	localparam int COORD_MAX    = (1 << FIELD_BITS) - 1;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_TICKS = 8;

	typedef struct packed {
		logic [FIELD_BITS-1:0] x;
		logic [FIELD_BITS-1:0] y;
		logic                  visible;
		logic                  last;
	} pixel_t;

	class pixel_scoreboard;
		pixel_t              pending_pixels[$];
		logic [IMG_BITS-1:0] img_w = IMG_SIZE_RESET;
		logic [IMG_BITS-1:0] img_h = IMG_SIZE_RESET;
		int                  errors = 0;
		int                  lines_seen = 0;
		int                  pixels_seen = 0;

		function void set_image_size(logic [APB_ADDR_BITS-1:0] addr,
			logic [APB_DATA_BITS-1:0] data);
			if (addr[2] == REG_IMAGE_WIDTH)
				img_w = data[IMG_BITS-1:0];
			else
				img_h = data[IMG_BITS-1:0];
		endfunction

		// walk the line as the block does and queue every pixel it should emit
		function void rasterize_line(logic [S_TDATA_BITS-1:0] word);
			int sx, sy, ex, ey, dx, dy, t;
			int maj, mnr, maj_d, min_d, step, err;
			bit x_major;
			pixel_t p;
			sx = word[FIELD_BITS-1:0];
			sy = word[2*FIELD_BITS-1:FIELD_BITS];
			ex = word[3*FIELD_BITS-1:2*FIELD_BITS];
			ey = word[4*FIELD_BITS-1:3*FIELD_BITS];
			dx = ex > sx ? ex - sx : sx - ex;
			dy = ey > sy ? ey - sy : sy - ey;
			x_major = dx > dy;
			if (x_major ? (ex < sx) : (ey < sy)) begin
				t = sx; sx = ex; ex = t;
				t = sy; sy = ey; ey = t;
			end
			if (x_major) begin
				maj = sx; mnr = sy; maj_d = dx; min_d = dy;
				step = ey < sy ? -1 : 1;
			end else begin
				maj = sy; mnr = sx; maj_d = dy; min_d = dx;
				step = ex < sx ? -1 : 1;
			end
			err = 0;
			for (int k = 0; k <= maj_d; k++) begin
				p.x = FIELD_BITS'(x_major ? maj : mnr);
				p.y = FIELD_BITS'(x_major ? mnr : maj);
				p.visible = (p.x < img_w) && (p.y < img_h);
				p.last = (k == maj_d);
				pending_pixels.push_back(p);
				err += min_d;
				if (2 * err >= maj_d) begin
					mnr += step;
					err -= maj_d;
				end
				maj++;
			end
			lines_seen++;
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$error("pixel (%0d,%0d) with nothing expected", got.x, got.y);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.x !== want.x) begin
				$error("pixel_x: expected %0d, got %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("pixel_y: expected %0d, got %0d", want.y, got.y);
				errors++;
			end
			if (got.visible !== want.visible) begin
				$error("visible: expected %0d, got %0d", want.visible, got.visible);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [S_TDATA_BITS-1:0]  s_tdata = '0;  // start_x, start_y, end_x, end_y
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0]  m_tdata;       // pixel_x, pixel_y, 4'b0 pad
	logic                     m_tuser;       // visible
	logic                     m_tlast;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	pixel_scoreboard sb = new();
	int idle_cycles = 0;
	int ready_hold = 0;

	bresenham_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// all three interfaces observed at the edge, in the order they can interact
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				sb.set_image_size(paddr, pwdata);
			if (s_tvalid && s_tready)
				sb.rasterize_line(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_pixel({m_tdata[FIELD_BITS-1:0], m_tdata[2*FIELD_BITS-1:FIELD_BITS],
					m_tuser, m_tlast});
		end
	end

	// output backpressure: mostly short bursts, a few long stalls and long open stretches
	always @(posedge clk) begin
		int r;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				m_tready <= 1'b1;
				ready_hold <= $urandom_range(0, 5);
			end else if (r < 90) begin
				m_tready <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else if (r < 96) begin
				m_tready <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end else begin
				m_tready <= 1'b1;
				ready_hold <= $urandom_range(50, 150);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_line(input int sx, input int sy, input int ex, input int ey);
		int r, gap;
		r = $urandom_range(0, 99);
		if (r < 50)      gap = 0;
		else if (r < 85) gap = $urandom_range(1, 3);
		else if (r < 95) gap = $urandom_range(4, 8);
		else             gap = $urandom_range(15, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {FIELD_BITS'(ey), FIELD_BITS'(ex), FIELD_BITS'(sy), FIELD_BITS'(sx)};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_line();
		int r, sx, sy, ex, ey, d, t;
		r = $urandom_range(0, 99);
		sx = $urandom_range(0, COORD_MAX);
		sy = $urandom_range(0, COORD_MAX);
		if (r < 55) begin
			ex = $urandom_range(0, COORD_MAX);
			ey = $urandom_range(0, COORD_MAX);
		end else if (r < 80) begin
			// short lines keep the handshakes busy
			ex = $urandom_range(sx < 4 ? 0 : sx - 4, sx > COORD_MAX - 4 ? COORD_MAX : sx + 4);
			ey = $urandom_range(sy < 4 ? 0 : sy - 4, sy > COORD_MAX - 4 ? COORD_MAX : sy + 4);
		end else if (r < 92) begin
			// |dx| == |dy|, where y wins the major axis
			d = $urandom_range(0, COORD_MAX);
			sx = $urandom_range(0, COORD_MAX - d);
			sy = $urandom_range(0, COORD_MAX - d);
			ex = sx + d;
			ey = sy + d;
			if ($urandom_range(0, 1)) begin t = sx; sx = ex; ex = t; end
		end else begin
			ex = $urandom_range(0, 1) ? sx : $urandom_range(0, COORD_MAX);
			ey = (ex == sx) ? $urandom_range(0, COORD_MAX) : sy;
		end
		send_line(sx, sy, ex, ey);
	endtask

	task automatic apb_write(input logic [APB_ADDR_BITS-1:0] addr,
		input logic [APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// reconfigure only once the walker has drained; the wait before the check lets the
	// monitor queue a line accepted at the edge the sender returned on
	task automatic set_image(input logic [APB_DATA_BITS-1:0] w, input logic [APB_DATA_BITS-1:0] h);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		apb_write(ADDR_IMAGE_WIDTH, w);
		apb_write(ADDR_IMAGE_HEIGHT, h);
	endtask

	task automatic random_phase(input int count);
		repeat (count) random_line();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at reset image size
		send_line(0, 0, 0, 0);
		send_line(63, 63, 63, 63);
		send_line(0, 0, 63, 0);
		send_line(63, 5, 0, 5);
		send_line(7, 0, 7, 63);
		send_line(9, 63, 9, 0);
		send_line(0, 0, 63, 63);
		send_line(63, 0, 0, 63);
		send_line(0, 63, 63, 0);
		send_line(0, 0, 63, 10);
		send_line(5, 0, 20, 63);
		send_line(63, 0, 0, 20);
		send_line(40, 63, 30, 0);
		send_line(0, 0, 5, 4);
		send_line(10, 10, 11, 10);
		send_line(10, 10, 10, 11);
		send_line(20, 30, 19, 31);
		send_line(42, 21, 21, 42);

		set_image(1, 1);
		send_line(0, 0, 1, 1);
		send_line(2, 0, 0, 2);
		random_phase(30);
		// a zero size hides everything
		set_image(0, 0);
		random_phase(25);
		// upper bits of pwdata are dropped: both registers land on 127
		set_image(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_line(0, 0, 63, 63);
		random_phase(30);
		set_image(64, 1);
		random_phase(30);
		set_image(1, 64);
		random_phase(30);
		set_image($urandom_range(1, 64), $urandom_range(1, 64));
		random_phase(15);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("%0d lines rasterized into %0d pixels, image sizes 0, 1, 64, 127 and random",
			sb.lines_seen, sb.pixels_seen);
		$display("under random gaps on the input side and random stalls on the output side");
		if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/blr_pkg.sv
design/blr_cfg.sv
design/blr_setup.sv
design/blr_walk.sv
design/bresenham_line_rasterizer.sv
sim/tb_bresenham_line_rasterizer.sv
